/* hw/rtl/ids_pkg.sv */
// shared definitions for the indexed deck sampler
// operation and status codes, field widths and controller/datapath interface structs
// no dependencies
package ids_pkg;

    localparam int DECK_SIZE_DEF = 52;

    localparam int OP_W    = 3;
    localparam int FIELD_W = 6;
    localparam int ST_W    = 3;
    localparam int CMP_W   = 7;

    localparam logic [OP_W-1:0] OP_DRAW   = 3'd0;
    localparam logic [OP_W-1:0] OP_RETURN = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL       = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_IN     = 3'd3;
    localparam logic [ST_W-1:0] ST_ALREADY_IN = 3'd4;
    localparam logic [ST_W-1:0] ST_BAD        = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic lookup;
        logic plan;
        logic capture;
        logic wr1;
        logic wr2;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic plan_swap;
        logic plan_ret;
    } t_sts;

endpackage

/* hw/rtl/indexed_deck_sampler.sv */
// indexed deck sampler top level: sampling without replacement from a deck
// instantiates ids_ctrl and ids_dpath; uses ids_pkg
//
// input channel: i_valid / o_stall with i_operation, i_draw_index, i_item_id
//   (draw, return last drawn, remove named item, add named item, reset pool)
// output channel: o_valid / i_stall with o_drawn_item, o_status, o_pool_count,
//   exactly one result transfer for every input transfer, in order
// one operation is in flight at a time; o_stall is high from the accepting edge
//   until the result is loaded into the output register
// steps per operation: accept, lookup, plan, then a data capture (return), a data
//   capture with the first swap write and then the second swap write
//   (draw/remove/add), or neither (errors, pool reset), then output load; the slot
//   and item maps have one write port each, so a swap is written in two halves,
//   and every map read is registered
// the output register holds a finished result while the receiver stalls; the
//   next operation is accepted and runs, and waits for the register only at
//   its end
// i_rst_n (synchronous): pool back to a full deck, slot i holds item i,
//   output register empty
module indexed_deck_sampler #(
    parameter int DECK_SIZE = ids_pkg::DECK_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ids_pkg::OP_W-1:0]       i_operation,
    input  logic [ids_pkg::FIELD_W-1:0]    i_draw_index,
    input  logic [ids_pkg::FIELD_W-1:0]    i_item_id,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ids_pkg::FIELD_W-1:0]    o_drawn_item,
    output logic [ids_pkg::ST_W-1:0]       o_status,
    output logic [ids_pkg::FIELD_W-1:0]    o_pool_count
);

    // command and status between controller and datapath
    ids_pkg::t_cmd cmd;
    ids_pkg::t_sts sts;

    // sequencer: lookup of the named item's slot, plan, map reads, two swap
    // writes, then output load once the output register is free
    ids_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // maps, pool count and result register
    ids_dpath #(
        .DECK_SIZE (DECK_SIZE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_operation  (i_operation),
        .i_draw_index (i_draw_index),
        .i_item_id    (i_item_id),
        .o_drawn_item (o_drawn_item),
        .o_status     (o_status),
        .o_pool_count (o_pool_count)
    );

endmodule

/* hw/rtl/ids_ctrl.sv */
// controller state machine of the indexed deck sampler
// sequences lookup, plan, swap writes and output load; uses ids_pkg
module ids_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  ids_pkg::t_sts i_sts,
    output ids_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_PLAN   = 3'd2;
    localparam logic [2:0] S_DATA   = 3'd3;
    localparam logic [2:0] S_SWAP2  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_swap;
    logic       n_swap;
    logic       r_o_valid;
    logic       n_o_valid;
    logic       out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_o_valid;
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_swap  = r_swap;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_swap     = i_sts.plan_swap;
                if (i_sts.plan_swap || i_sts.plan_ret) begin
                    n_state = S_DATA;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DATA: begin
                o_cmd.capture = 1'b1;
                if (r_swap) begin
                    o_cmd.wr1 = 1'b1;
                    n_state   = S_SWAP2;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SWAP2: begin
                o_cmd.wr2 = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (o_cmd.load_out) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_swap    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_swap    <= n_swap;
            r_o_valid <= n_o_valid;
        end
    end

endmodule

/* hw/rtl/ids_dpath.sv */
// datapath of the indexed deck sampler: slot/item maps, pool count, result register
// maps are single-write memories with registered reads; uses ids_pkg
module ids_dpath #(
    parameter int DECK_SIZE = ids_pkg::DECK_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ids_pkg::t_cmd                  i_cmd,
    output ids_pkg::t_sts                  o_sts,
    input  logic [ids_pkg::OP_W-1:0]       i_operation,
    input  logic [ids_pkg::FIELD_W-1:0]    i_draw_index,
    input  logic [ids_pkg::FIELD_W-1:0]    i_item_id,
    output logic [ids_pkg::FIELD_W-1:0]    o_drawn_item,
    output logic [ids_pkg::ST_W-1:0]       o_status,
    output logic [ids_pkg::FIELD_W-1:0]    o_pool_count
);

    localparam int AW = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
    localparam int CW = $clog2(DECK_SIZE + 1);
    localparam logic [CW-1:0]               FullCount = CW'(DECK_SIZE);
    localparam logic [ids_pkg::CMP_W-1:0]   DeckCmp   = ids_pkg::CMP_W'(DECK_SIZE);

    // latched operation
    logic [ids_pkg::OP_W-1:0]    r_op;
    logic [ids_pkg::FIELD_W-1:0] r_idx;
    logic [ids_pkg::FIELD_W-1:0] r_item;
    logic [CW-1:0]               r_pool;

    // planned swap
    logic [AW-1:0]               r_a;
    logic [AW-1:0]               r_b;
    logic [AW-1:0]               r_ia;
    logic [AW-1:0]               r_ib;
    logic [ids_pkg::ST_W-1:0]    r_status;
    logic [ids_pkg::FIELD_W-1:0] r_drawn;

    // result register
    logic [ids_pkg::FIELD_W-1:0] r_out_drawn;
    logic [ids_pkg::ST_W-1:0]    r_out_status;
    logic [ids_pkg::FIELD_W-1:0] r_out_pool;

    // maps
    logic [AW-1:0]        r_ias_mem [DECK_SIZE];
    logic [AW-1:0]        r_soi_mem [DECK_SIZE];
    logic [DECK_SIZE-1:0] r_ias_vld;
    logic [DECK_SIZE-1:0] r_soi_vld;

    // registered read ports, unwritten entries read as their own address
    logic [AW-1:0] r_soi_q;
    logic          r_soi_qv;
    logic [AW-1:0] r_soi_qaddr;
    logic [AW-1:0] r_ias_qa;
    logic          r_ias_qav;
    logic [AW-1:0] r_ias_qaaddr;
    logic [AW-1:0] r_ias_qb;
    logic          r_ias_qbv;
    logic [AW-1:0] r_ias_qbaddr;

    logic [AW-1:0] soi_val;
    logic [AW-1:0] ias_a_val;
    logic [AW-1:0] ias_b_val;
    logic [AW-1:0] soi_raddr;
    logic          item_ok;
    logic          slot_in;

    logic [ids_pkg::ST_W-1:0] plan_status;
    logic [AW-1:0]            plan_a;
    logic [AW-1:0]            plan_b;
    logic                     plan_swap;
    logic                     plan_ret;
    logic [CW-1:0]            n_pool;

    logic          mem_we;
    logic [AW-1:0] ias_waddr;
    logic [AW-1:0] ias_wdata;
    logic [AW-1:0] soi_waddr;
    logic [AW-1:0] soi_wdata;

    assign soi_val   = r_soi_qv  ? r_soi_q  : r_soi_qaddr;
    assign ias_a_val = r_ias_qav ? r_ias_qa : r_ias_qaaddr;
    assign ias_b_val = r_ias_qbv ? r_ias_qb : r_ias_qbaddr;

    assign item_ok   = {1'b0, r_item} < DeckCmp;
    assign soi_raddr = item_ok ? r_item[AW-1:0] : '0;
    assign slot_in   = ids_pkg::CMP_W'(soi_val) < ids_pkg::CMP_W'(r_pool);

    // decide the operation once the item's slot is known
    always_comb begin
        plan_status = ids_pkg::ST_OK;
        plan_a      = '0;
        plan_b      = '0;
        plan_swap   = 1'b0;
        plan_ret    = 1'b0;
        n_pool      = r_pool;
        unique case (r_op)
            ids_pkg::OP_DRAW: begin
                if (r_pool == '0) begin
                    plan_status = ids_pkg::ST_EMPTY;
                end else if ({1'b0, r_idx} >= ids_pkg::CMP_W'(r_pool)) begin
                    plan_status = ids_pkg::ST_BAD;
                end else begin
                    plan_a    = r_idx[AW-1:0];
                    plan_b    = AW'(r_pool - 1'b1);
                    plan_swap = 1'b1;
                    n_pool    = r_pool - 1'b1;
                end
            end
            ids_pkg::OP_RETURN: begin
                if (r_pool >= FullCount) begin
                    plan_status = ids_pkg::ST_FULL;
                end else begin
                    plan_a   = AW'(r_pool);
                    plan_ret = 1'b1;
                    n_pool   = r_pool + 1'b1;
                end
            end
            ids_pkg::OP_REMOVE: begin
                if (!item_ok) begin
                    plan_status = ids_pkg::ST_BAD;
                end else if (!slot_in) begin
                    plan_status = ids_pkg::ST_NOT_IN;
                end else begin
                    plan_a    = soi_val;
                    plan_b    = AW'(r_pool - 1'b1);
                    plan_swap = 1'b1;
                    n_pool    = r_pool - 1'b1;
                end
            end
            ids_pkg::OP_ADD: begin
                if (!item_ok) begin
                    plan_status = ids_pkg::ST_BAD;
                end else if (slot_in) begin
                    plan_status = ids_pkg::ST_ALREADY_IN;
                end else begin
                    plan_a    = soi_val;
                    plan_b    = AW'(r_pool);
                    plan_swap = 1'b1;
                    n_pool    = r_pool + 1'b1;
                end
            end
            ids_pkg::OP_RESET: begin
                n_pool = FullCount;
            end
            default: begin
                plan_status = ids_pkg::ST_BAD;
            end
        endcase
    end

    assign o_sts.plan_swap = plan_swap;
    assign o_sts.plan_ret  = plan_ret;

    // swap writes: first half uses the fresh read data, second half the captured copy
    always_comb begin
        mem_we    = i_cmd.wr1 || i_cmd.wr2;
        ias_waddr = r_b;
        ias_wdata = r_ia;
        soi_waddr = r_ib;
        soi_wdata = r_a;
        if (i_cmd.wr1) begin
            ias_waddr = r_a;
            ias_wdata = ias_b_val;
            soi_waddr = ias_a_val;
            soi_wdata = r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ias_mem[ias_waddr] <= ias_wdata;
            r_soi_mem[soi_waddr] <= soi_wdata;
        end
        if (i_cmd.lookup) begin
            r_soi_q     <= r_soi_mem[soi_raddr];
            r_soi_qv    <= r_soi_vld[soi_raddr];
            r_soi_qaddr <= soi_raddr;
        end
        if (i_cmd.plan) begin
            r_ias_qa     <= r_ias_mem[plan_a];
            r_ias_qav    <= r_ias_vld[plan_a];
            r_ias_qaaddr <= plan_a;
            r_ias_qb     <= r_ias_mem[plan_b];
            r_ias_qbv    <= r_ias_vld[plan_b];
            r_ias_qbaddr <= plan_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ias_vld <= '0;
            r_soi_vld <= '0;
            r_pool    <= FullCount;
        end else begin
            if (mem_we) begin
                r_ias_vld[ias_waddr] <= 1'b1;
                r_soi_vld[soi_waddr] <= 1'b1;
            end
            if (i_cmd.plan) begin
                r_pool <= n_pool;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_operation;
            r_idx  <= i_draw_index;
            r_item <= i_item_id;
        end
        if (i_cmd.plan) begin
            r_a      <= plan_a;
            r_b      <= plan_b;
            r_status <= plan_status;
            r_drawn  <= '0;
        end
        if (i_cmd.capture) begin
            r_ia <= ias_a_val;
            r_ib <= ias_b_val;
            if (r_op == ids_pkg::OP_DRAW || r_op == ids_pkg::OP_RETURN) begin
                r_drawn <= ids_pkg::FIELD_W'(ias_a_val);
            end
        end
        if (i_cmd.load_out) begin
            r_out_drawn  <= r_drawn;
            r_out_status <= r_status;
            r_out_pool   <= ids_pkg::FIELD_W'(r_pool);
        end
    end

    assign o_drawn_item = r_out_drawn;
    assign o_status     = r_out_status;
    assign o_pool_count = r_out_pool;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// testbench for indexed_deck_sampler: directed corner cases, a drain and refill pass and
// a long random walk, checked against a predictor of the deck permutation and pool size
// depends on ids_pkg and the indexed_deck_sampler RTL
module tb;

    localparam int DECK        = ids_pkg::DECK_SIZE_DEF;
    localparam int OP_W        = ids_pkg::OP_W;
    localparam int FIELD_W     = ids_pkg::FIELD_W;
    localparam int ST_W        = ids_pkg::ST_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_GUARD = 20;

    // operation codes the block treats as unknown
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [FIELD_W-1:0] item;
        logic [ST_W-1:0]    status;
        logic [FIELD_W-1:0] count;
    } t_deck_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [OP_W-1:0]    i_operation;
    logic [FIELD_W-1:0] i_draw_index;
    logic [FIELD_W-1:0] i_item_id;
    logic               o_valid;
    logic               i_stall;
    logic [FIELD_W-1:0] o_drawn_item;
    logic [ST_W-1:0]    o_status;
    logic [FIELD_W-1:0] o_pool_count;

    // predicted deck: which card sits in each slot, where each card sits, and pool size
    logic [FIELD_W-1:0] deck_order [DECK];
    logic [FIELD_W-1:0] card_slot  [DECK];
    int                 pool_left;

    t_deck_result pending_results [$];
    int           err_count;
    int           idle_pct;
    int           cycles;

    indexed_deck_sampler #(
        .DECK_SIZE (DECK)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_draw_index (i_draw_index),
        .i_item_id    (i_item_id),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_drawn_item (o_drawn_item),
        .o_status     (o_status),
        .o_pool_count (o_pool_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run guard: a hang anywhere ends here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void swap_slots(int a, int b);
        logic [FIELD_W-1:0] card_a;
        logic [FIELD_W-1:0] card_b;
        card_a = deck_order[a];
        card_b = deck_order[b];
        card_slot[card_a] = FIELD_W'(b);
        card_slot[card_b] = FIELD_W'(a);
        deck_order[a] = card_b;
        deck_order[b] = card_a;
    endfunction

    // applies one operation to the predicted deck and returns the result it should give
    function automatic t_deck_result apply_deck_op(logic [OP_W-1:0] op,
                                                   logic [FIELD_W-1:0] idx,
                                                   logic [FIELD_W-1:0] card);
        t_deck_result r;
        int           hole;
        r        = '0;
        r.status = ids_pkg::ST_OK;
        case (op)
            ids_pkg::OP_DRAW: begin
                if (pool_left == 0) begin
                    r.status = ids_pkg::ST_EMPTY;
                end else if (int'(idx) >= pool_left) begin
                    r.status = ids_pkg::ST_BAD;
                end else begin
                    // chosen slot goes to the top of the pool, which then shrinks past it
                    pool_left--;
                    swap_slots(int'(idx), pool_left);
                    r.item = deck_order[pool_left];
                end
            end
            ids_pkg::OP_RETURN: begin
                if (pool_left >= DECK) begin
                    r.status = ids_pkg::ST_FULL;
                end else begin
                    r.item = deck_order[pool_left];
                    pool_left++;
                end
            end
            ids_pkg::OP_REMOVE, ids_pkg::OP_ADD: begin
                if (int'(card) >= DECK) begin
                    r.status = ids_pkg::ST_BAD;
                end else begin
                    hole = int'(card_slot[card]);
                    if (op == ids_pkg::OP_REMOVE) begin
                        if (hole >= pool_left) begin
                            r.status = ids_pkg::ST_NOT_IN;
                        end else begin
                            swap_slots(hole, pool_left - 1);
                            pool_left--;
                        end
                    end else begin
                        if (hole < pool_left) begin
                            r.status = ids_pkg::ST_ALREADY_IN;
                        end else begin
                            swap_slots(hole, pool_left);
                            pool_left++;
                        end
                    end
                end
            end
            ids_pkg::OP_RESET: begin
                pool_left = DECK;
            end
            default: begin
                r.status = ids_pkg::ST_BAD;
            end
        endcase
        r.count = FIELD_W'(pool_left);
        return r;
    endfunction

    // ---------------------------------------------------------------- channels

    // one input transfer; called and returns at a falling edge, valid stays up after
    // the transfer so back-to-back items need no extra edge
    task automatic send_op(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] idx,
                           input logic [FIELD_W-1:0] card);
        while ($urandom_range(99, 0) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_draw_index <= idx;
        i_item_id    <= card;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(apply_deck_op(op, idx, card));
        @(negedge i_clk);
    endtask

    // receiver stalls at random
    initial begin
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99, 0) < idle_pct);
        end
    end

    // every result transfer is matched against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_deck_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: item %0d status %0d count %0d",
                       o_drawn_item, o_status, o_pool_count);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_drawn_item !== want.item) begin
                    $error("drawn_item: expected %0d, got %0d", want.item, o_drawn_item);
                    err_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (o_pool_count !== want.count) begin
                    $error("pool_count: expected %0d, got %0d", want.count, o_pool_count);
                    err_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // extremes of both index fields, every operation and every error status but empty
    task automatic test_corners();
        send_op(ids_pkg::OP_DRAW, 6'd51, 6'd0);      // top slot, no real swap
        send_op(ids_pkg::OP_DRAW, 6'd0, 6'd63);      // bottom slot swaps with the top
        send_op(ids_pkg::OP_DRAW, 6'd50, 6'd0);      // index equal to pool size
        send_op(ids_pkg::OP_DRAW, 6'd63, 6'd0);      // index far out of range
        send_op(ids_pkg::OP_RETURN, 6'd63, 6'd63);
        send_op(ids_pkg::OP_REMOVE, 6'd0, 6'd0);
        send_op(ids_pkg::OP_REMOVE, 6'd0, 6'd0);     // already out of the pool
        send_op(ids_pkg::OP_ADD, 6'd0, 6'd0);
        send_op(ids_pkg::OP_ADD, 6'd0, 6'd0);        // already in the pool
        send_op(ids_pkg::OP_REMOVE, 6'd0, 6'd52);    // card id past the deck
        send_op(ids_pkg::OP_ADD, 6'd0, 6'd63);
        send_op(ids_pkg::OP_REMOVE, 6'd0, 6'd51);    // drawn earlier, not in the pool
        send_op(ids_pkg::OP_ADD, 6'd0, 6'd51);       // back to a full deck
        send_op(ids_pkg::OP_RETURN, 6'd0, 6'd0);     // nothing to return
        send_op(ids_pkg::OP_DRAW, 6'd42, 6'd21);
        send_op(ids_pkg::OP_DRAW, 6'd21, 6'd42);
        send_op(ids_pkg::OP_REMOVE, 6'd63, 6'd42);
        send_op(ids_pkg::OP_ADD, 6'd63, 6'd21);      // drawn just before, goes back in
        send_op(ids_pkg::OP_RESET, 6'd63, 6'd63);    // partial pool back to full
        send_op(ids_pkg::OP_RESET, 6'd0, 6'd0);      // reset of a full pool
        send_op(OP_SPARE_LO, 6'd63, 6'd63);
        send_op(OP_SPARE_MID, 6'd21, 6'd42);
        send_op(OP_SPARE_HI, 6'd0, 6'd0);
    endtask

    // empty the pool with no idling on either side, poke it while empty, refill it
    task automatic test_drain_refill();
        int slot;
        idle_pct = 0;
        while (pool_left > 0)
            send_op(ids_pkg::OP_DRAW, FIELD_W'($urandom_range(pool_left - 1, 0)),
                    FIELD_W'($urandom_range(63, 0)));
        send_op(ids_pkg::OP_DRAW, 6'd0, 6'd0);
        send_op(ids_pkg::OP_DRAW, 6'd63, 6'd63);
        send_op(ids_pkg::OP_REMOVE, 6'd0, FIELD_W'($urandom_range(DECK - 1, 0)));
        while (pool_left < DECK) begin
            if ($urandom_range(1, 0) == 0) begin
                send_op(ids_pkg::OP_RETURN, FIELD_W'($urandom_range(63, 0)), 6'd0);
            end else begin
                slot = $urandom_range(DECK - 1, pool_left);
                send_op(ids_pkg::OP_ADD, FIELD_W'($urandom_range(63, 0)), deck_order[slot]);
            end
        end
        send_op(ids_pkg::OP_RETURN, 6'd0, 6'd0);
        idle_pct = 11;
    endtask

    // random walk that swings between draining and filling so both ends are reached;
    // mostly legal operations, with a share of unconstrained fields and spare codes
    task automatic test_random_walk(input int n_ops);
        bit draining;
        int pick;
        int slot;
        bit take;
        draining = 1'b1;
        for (int k = 0; k < n_ops; k++) begin
            if (k % 150 == 149)
                draining = ~draining;
            pick = $urandom_range(99, 0);
            if (pick < 8) begin
                send_op(OP_W'($urandom_range(7, 0)), FIELD_W'($urandom_range(63, 0)),
                        FIELD_W'($urandom_range(63, 0)));
            end else if (pick < 9) begin
                send_op(ids_pkg::OP_RESET, FIELD_W'($urandom_range(63, 0)),
                        FIELD_W'($urandom_range(63, 0)));
            end else if (pick < 11) begin
                send_op(OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)),
                        FIELD_W'($urandom_range(63, 0)), FIELD_W'($urandom_range(63, 0)));
            end else begin
                take = ($urandom_range(99, 0) < 70) ? draining : ~draining;
                if (pool_left == 0)
                    take = 1'b0;
                else if (pool_left == DECK)
                    take = 1'b1;
                if (take) begin
                    slot = $urandom_range(pool_left - 1, 0);
                    if ($urandom_range(1, 0) == 0)
                        send_op(ids_pkg::OP_DRAW, FIELD_W'(slot),
                                FIELD_W'($urandom_range(63, 0)));
                    else
                        send_op(ids_pkg::OP_REMOVE, FIELD_W'($urandom_range(63, 0)),
                                deck_order[slot]);
                end else begin
                    slot = $urandom_range(DECK - 1, pool_left);
                    if ($urandom_range(1, 0) == 0)
                        send_op(ids_pkg::OP_RETURN, FIELD_W'($urandom_range(63, 0)),
                                FIELD_W'($urandom_range(63, 0)));
                    else
                        send_op(ids_pkg::OP_ADD, FIELD_W'($urandom_range(63, 0)),
                                deck_order[slot]);
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_operation  = ids_pkg::OP_DRAW;
        i_draw_index = '0;
        i_item_id    = '0;
        err_count    = 0;
        idle_pct     = 11;
        cycles       = 0;
        for (int k = 0; k < DECK; k++) begin
            deck_order[k] = FIELD_W'(k);
            card_slot[k]  = FIELD_W'(k);
        end
        pool_left = DECK;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_corners();
        test_drain_refill();
        test_random_walk(1370);

        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // room for a stray extra transfer to show up
        repeat (DRAIN_GUARD) @(posedge i_clk);

        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
